/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the bridge light controller.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define OLB_ASSERT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define OLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/olblc_pkg.sv */
// Package for the one-lane bridge light controller: beat types, codes, register map.
// No dependencies.
`default_nettype none

package olblc_pkg;

	// Queue depth default
	localparam int unsigned OLBLC_QUEUE_MAX = 255;

	// Configuration port geometry
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [1:0] REG_MAX_STREAM  = 2'd0;
	localparam logic [1:0] REG_IDLE_POLL   = 2'd1;
	localparam logic [1:0] REG_CAR_GAP     = 2'd2;
	localparam logic [1:0] REG_TRAVEL      = 2'd3;

	// Register reset values
	localparam logic [3:0] RST_MAX_STREAM  = 4'd4;
	localparam logic [2:0] RST_IDLE_POLL   = 3'd2;
	localparam logic [2:0] RST_CAR_GAP     = 3'd1;
	localparam logic [2:0] RST_TRAVEL      = 3'd5;

	// Event opcodes
	localparam logic [2:0] OP_NORTH_ARRIVE = 3'd0;
	localparam logic [2:0] OP_SOUTH_ARRIVE = 3'd1;
	localparam logic [2:0] OP_NORTH_ENTER  = 3'd2;
	localparam logic [2:0] OP_SOUTH_ENTER  = 3'd3;
	localparam logic [2:0] OP_DISPATCH     = 3'd4;

	// Light codes
	localparam logic [3:0] LIGHT_RED       = 4'hA;
	localparam logic [3:0] LIGHT_NORTH     = 4'h9;
	localparam logic [3:0] LIGHT_SOUTH     = 4'h6;
	localparam logic [3:0] LIGHT_NONE      = 4'h0;

	// Bridge entry codes
	localparam logic [1:0] ADD_NONE        = 2'd0;
	localparam logic [1:0] ADD_NORTH       = 2'd1;
	localparam logic [1:0] ADD_SOUTH       = 2'd2;

	// Display saturation
	localparam logic [7:0] SHOWN_MAX       = 8'hFF;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] cars_on_bridge_north;
		logic [7:0] cars_on_bridge_south;
	} evt_beat_t;

	typedef struct packed {
		logic       signal_valid;
		logic [3:0] light_code;
		logic       next_tick_valid;
		logic [2:0] next_tick_seconds;
		logic [1:0] bridge_add;
		logic [7:0] north_waiting;
		logic [7:0] south_waiting;
	} res_beat_t;

	typedef struct packed {
		logic [3:0] max_stream_cars;
		logic [2:0] idle_poll_seconds;
		logic [2:0] car_gap_seconds;
		logic [2:0] travel_seconds;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/one_lane_bridge_light_controller.sv */
// Top level of the one-lane bridge light controller: input register, engine, result register.
// Depends on olblc_pkg, olblc_regs and olblc_engine.
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+------------------------
//  evt     | evt_valid, evt_stall, evt        | in        | opcode, bridge counts
//  res     | res_valid, res_stall, res        | out       | light, tick, counts
//  cfg     | psel, penable, pwrite, paddr ... | in        | four config registers
//
// One beat accepted per cycle while evt_stall is low; the event beat is captured in the
// input register and its result beat in the result register, with the decision logic
// between them.
// Every event beat gives exactly one result beat.
// Reset clears the queues and stream count, selects north first and loads
// the register defaults. A stalled result holds; evt_stall rises only when
// the input register is full and cannot move on into the result register.
`default_nettype none

module one_lane_bridge_light_controller
	import olblc_pkg::*;
#(
	parameter int unsigned QUEUE_MAX = OLBLC_QUEUE_MAX
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  evt_valid,
	output logic                       evt_stall,
	input  wire evt_beat_t             evt,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_beat_t                  res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t      cfg;
	evt_beat_t evt_s1;
	logic      vld_s1;
	res_beat_t res_s2;
	logic      vld_s2;
	res_beat_t res_d;
	logic      adv;
	logic      take;

	olblc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	olblc_engine #(
		.QUEUE_MAX (QUEUE_MAX)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Handshake
	assign adv       = vld_s1 & (~vld_s2 | ~res_stall);
	assign evt_stall = vld_s1 & ~adv;
	assign take      = evt_valid & ~evt_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			evt_s1 <= evt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

/* rtl/core/olblc_regs.sv */
// Configuration register file of the bridge light controller, APB-style slave.
// Depends on olblc_pkg.
`default_nettype none

module olblc_regs
	import olblc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes, masked to field width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_stream_cars   <= RST_MAX_STREAM;
			cfg_q.idle_poll_seconds <= RST_IDLE_POLL;
			cfg_q.car_gap_seconds   <= RST_CAR_GAP;
			cfg_q.travel_seconds    <= RST_TRAVEL;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_STREAM: cfg_q.max_stream_cars   <= pwdata[3:0];
				REG_IDLE_POLL:  cfg_q.idle_poll_seconds <= pwdata[2:0];
				REG_CAR_GAP:    cfg_q.car_gap_seconds   <= pwdata[2:0];
				REG_TRAVEL:     cfg_q.travel_seconds    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_MAX_STREAM: prdata = {28'd0, cfg_q.max_stream_cars};
			REG_IDLE_POLL:  prdata = {29'd0, cfg_q.idle_poll_seconds};
			REG_CAR_GAP:    prdata = {29'd0, cfg_q.car_gap_seconds};
			REG_TRAVEL:     prdata = {29'd0, cfg_q.travel_seconds};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/olblc_engine.sv */
// Queue counters, stream state and dispatch decision of the bridge light controller.
// Depends on olblc_pkg.
`default_nettype none

module olblc_engine
	import olblc_pkg::*;
#(
	parameter int unsigned QUEUE_MAX = OLBLC_QUEUE_MAX
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire evt_beat_t evt,
	input  wire cfg_t      cfg,
	output res_beat_t      res
);

	localparam int QW = $clog2(QUEUE_MAX + 1);
	localparam int SW = (QW > 8) ? QW : 8;
	localparam logic [QW-1:0] QMAX = QW'(QUEUE_MAX);

	logic [QW-1:0] north_q, south_q;
	logic          serving_north_q;
	logic [3:0]    stream_count_q;

	logic [QW-1:0] north_d, south_d;
	logic          serving_north_d;
	logic [3:0]    stream_count_d;
	logic [SW-1:0] north_ext, south_ext;

	// Event decode and dispatch decision
	always_comb begin
		north_d         = north_q;
		south_d         = south_q;
		serving_north_d = serving_north_q;
		stream_count_d  = stream_count_q;
		res             = '0;

		case (evt.opcode)
			OP_NORTH_ARRIVE: begin
				if (north_q < QMAX) north_d = north_q + QW'(1);
			end
			OP_SOUTH_ARRIVE: begin
				if (south_q < QMAX) south_d = south_q + QW'(1);
			end
			OP_NORTH_ENTER: begin
				if (north_q != '0) north_d = north_q - QW'(1);
				res.bridge_add = ADD_NORTH;
			end
			OP_SOUTH_ENTER: begin
				if (south_q != '0) south_d = south_q - QW'(1);
				res.bridge_add = ADD_SOUTH;
			end
			OP_DISPATCH: begin
				res.next_tick_valid = 1'b1;
				if (north_q == '0 && south_q == '0) begin
					res.signal_valid      = 1'b1;
					res.light_code        = LIGHT_RED;
					res.next_tick_seconds = cfg.idle_poll_seconds;
				end else if (south_q == '0) begin
					// only north waits: hold while southbound cars clear
					if (evt.cars_on_bridge_south != 8'd0) begin
						res.next_tick_seconds = cfg.travel_seconds;
					end else begin
						res.signal_valid      = 1'b1;
						res.light_code        = LIGHT_NORTH;
						res.next_tick_seconds = cfg.car_gap_seconds;
					end
				end else if (north_q == '0) begin
					if (evt.cars_on_bridge_north != 8'd0) begin
						res.next_tick_seconds = cfg.travel_seconds;
					end else begin
						res.signal_valid      = 1'b1;
						res.light_code        = LIGHT_SOUTH;
						res.next_tick_seconds = cfg.car_gap_seconds;
					end
				end else begin
					// both wait: stream, then red gap and swap sides
					res.signal_valid = 1'b1;
					if (stream_count_q < cfg.max_stream_cars) begin
						res.light_code        = serving_north_q ? LIGHT_NORTH : LIGHT_SOUTH;
						stream_count_d        = stream_count_q + 4'd1;
						res.next_tick_seconds = cfg.car_gap_seconds;
					end else begin
						serving_north_d       = ~serving_north_q;
						stream_count_d        = 4'd0;
						res.light_code        = LIGHT_RED;
						res.next_tick_seconds = cfg.travel_seconds;
					end
				end
			end
			default: ;
		endcase

		// Displayed counts saturate at 255
		north_ext = SW'(north_d);
		south_ext = SW'(south_d);
		res.north_waiting = (north_ext > SW'(SHOWN_MAX)) ? SHOWN_MAX : north_ext[7:0];
		res.south_waiting = (south_ext > SW'(SHOWN_MAX)) ? SHOWN_MAX : south_ext[7:0];
	end

	// State update on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			north_q         <= '0;
			south_q         <= '0;
			serving_north_q <= 1'b1;
			stream_count_q  <= 4'd0;
		end else if (fire) begin
			north_q         <= north_d;
			south_q         <= south_d;
			serving_north_q <= serving_north_d;
			stream_count_q  <= stream_count_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/olblc_checker.sv */
// Port-level checker for the bridge light controller, bound to the top level.
// Depends on olblc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module olblc_checker
	import olblc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      res_valid,
	input  wire logic      res_stall,
	input  wire res_beat_t res
);

	// A held result beat keeps its contents
	`OLB_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "result beat changed while stalled")

	// Only a dispatch may carry a light or a delay
	`OLB_ASSERT(a_no_tick_quiet, clk, arst_n, res_valid && !res.next_tick_valid, !res.signal_valid && res.light_code == LIGHT_NONE && res.next_tick_seconds == 3'd0, "light or delay without dispatch")

	// Entry beats never schedule a tick
	`OLB_ASSERT(a_entry_no_tick, clk, arst_n, res_valid && res.bridge_add != ADD_NONE, !res.next_tick_valid && !res.signal_valid, "entry beat carries a dispatch result")

	// A sent light is one of the three codes; no light means code zero
	`OLB_ASSERT(a_light_code, clk, arst_n, res_valid, res.signal_valid ? (res.light_code == LIGHT_RED || res.light_code == LIGHT_NORTH || res.light_code == LIGHT_SOUTH) : (res.light_code == LIGHT_NONE), "bad light code")

endmodule

bind one_lane_bridge_light_controller olblc_checker u_checker (.*);

`default_nettype wire
